[design/horizon_column_renderer_with_text_defines.svh]
// Assertion macros shared by the checker of the horizon column renderer.
`ifndef HORIZON_COLUMN_RENDERER_WITH_TEXT_DEFINES_SVH
`define HORIZON_COLUMN_RENDERER_WITH_TEXT_DEFINES_SVH

// Same-cycle implication, sampled on clk and off while rst_n is low.
`define HCR_ASSERT_IMPLY(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("implication check failed");

// Next-cycle implication, sampled on clk and off while rst_n is low.
`define HCR_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

[design/hcr_pkg.sv]
// Types, constants and helper functions of the horizon column renderer.
`default_nettype none

package hcr_pkg;

    localparam int SCREEN_ROWS_DEF  = 128;
    localparam int TEXT_ROWS_DEF    = 7;
    localparam int TEXT_COLUMNS_DEF = 6;
    localparam int COL_MAX          = 6;

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam logic [15:0] SKY        = 16'h3F73;
    localparam logic [15:0] GROUND     = 16'hC563;
    localparam logic [15:0] MARKER     = 16'hE0FF;
    localparam logic [15:0] TXT_WHITE  = 16'hFFFF;
    localparam logic [15:0] TXT_CYAN   = 16'hFF07;
    localparam logic [15:0] TXT_YELLOW = 16'hE0FF;
    localparam logic [15:0] TXT_RED    = 16'h00F8;

    localparam logic [1:0] CI_WHITE  = 2'd0;
    localparam logic [1:0] CI_CYAN   = 2'd1;
    localparam logic [1:0] CI_YELLOW = 2'd2;
    localparam logic [1:0] CI_RED    = 2'd3;

    localparam logic [3:0] GLYPH_MINUS = 4'd10;
    localparam logic [3:0] GLYPH_DOT   = 4'd11;
    localparam logic [3:0] GLYPH_BLANK = 4'd15;

    localparam logic [6:0] MARKER_FIRST = 7'd56;
    localparam logic [6:0] MARKER_LAST  = 7'd72;
    localparam logic [6:0] MARKER_BASE  = 7'd64;

    localparam logic [15:0] PRINT_MOD   = 16'd10000;
    localparam logic [13:0] PLACE_1000  = 14'd1000;
    localparam logic [13:0] PLACE_100   = 14'd100;
    localparam logic [13:0] PLACE_10    = 14'd10;
    localparam logic [1:0]  STEP_LAST   = 2'd2;

    localparam int FONT_ENTRIES = 48;
    localparam logic [4:0] FONT_SLICES [FONT_ENTRIES] = '{
        5'h0E, 5'h11, 5'h11, 5'h0E, 5'h12, 5'h1F, 5'h10, 5'h00,
        5'h12, 5'h19, 5'h15, 5'h12, 5'h11, 5'h11, 5'h15, 5'h0A,
        5'h07, 5'h04, 5'h1F, 5'h04, 5'h17, 5'h15, 5'h15, 5'h09,
        5'h0E, 5'h15, 5'h15, 5'h09, 5'h11, 5'h09, 5'h05, 5'h03,
        5'h0A, 5'h15, 5'h15, 5'h0A, 5'h02, 5'h05, 5'h15, 5'h0E,
        5'h04, 5'h04, 5'h04, 5'h04, 5'h00, 5'h10, 5'h10, 5'h00
    };

    typedef logic [5:0] hcr_cell_t;

    typedef enum logic {KIND_PRINT, KIND_RENDER} hcr_kind_t;

    typedef enum logic [1:0] {HZ_SPLIT, HZ_SKY, HZ_GROUND} hcr_hz_t;

    typedef enum logic [1:0] {F_IDLE, F_MOD, F_DIGIT, F_PUSH} hcr_front_state_t;

    typedef enum logic {B_IDLE, B_RENDER} hcr_back_state_t;

    typedef struct packed {
        hcr_kind_t                  kind;
        logic [2:0]                 row;
        hcr_cell_t [COL_MAX-1:0]    cells;
        logic [6:0]                 top;
        logic [6:0]                 bottom;
        hcr_hz_t                    hz_mode;
        logic [6:0]                 hz_row;
        logic                       text_on;
        logic [2:0]                 tcol;
        logic [1:0]                 slice;
        logic                       marker_on;
        logic [6:0]                 marker_row;
    } hcr_cmd_t;

    function automatic logic [4:0] font_slice(input logic [3:0] g, input logic [1:0] s);
        logic [4:0] bits;
        bits = 5'd0;
        if (g <= GLYPH_DOT)
        begin
            bits = FONT_SLICES[{g, s}];
        end
        return bits;
    endfunction

    function automatic logic [15:0] text_colour(input logic [1:0] ci);
        logic [15:0] c;
        case (ci)
            CI_WHITE:  c = TXT_WHITE;
            CI_CYAN:   c = TXT_CYAN;
            CI_YELLOW: c = TXT_YELLOW;
            CI_RED:    c = TXT_RED;
            default:   c = TXT_WHITE;
        endcase
        return c;
    endfunction

    // The marker bulges downward by up to three rows around its center column.
    function automatic logic [6:0] marker_row_of(input logic [4:0] offset);
        logic [6:0] r;
        case (offset)
            5'd6, 5'd10: r = MARKER_BASE + 7'd1;
            5'd7, 5'd9:  r = MARKER_BASE + 7'd2;
            5'd8:        r = MARKER_BASE + 7'd3;
            default:     r = MARKER_BASE;
        endcase
        return r;
    endfunction

    function automatic logic [15:0] pixel_colour(input logic [6:0] y, input hcr_cmd_t cmd,
                                                 input hcr_cell_t glyph_cell, input logic hit);
        logic [15:0] c;
        logic [7:0]  bits;
        case (cmd.hz_mode)
            HZ_SKY:    c = SKY;
            HZ_GROUND: c = GROUND;
            default:   c = (y < cmd.hz_row) ? SKY : GROUND;
        endcase
        bits = {3'b000, font_slice(glyph_cell[3:0], cmd.slice)};
        if (hit && bits[y[2:0]])
        begin
            c = text_colour(glyph_cell[5:4]);
        end
        if (cmd.marker_on && (y == cmd.marker_row))
        begin
            c = MARKER;
        end
        return c;
    endfunction

endpackage

`default_nettype wire

[design/horizon_column_renderer_with_text.sv]
// Top level of the horizon column renderer with its small text overlay.
//
// One input channel takes requests: a print request stores a value as six glyphs
// in one text row and gives no output; a render request builds one display column
// and sends the changed row window as pixel pairs on the output channel.
// Both channels use valid and stall; a request moves when valid is high and stall low.
// The front part takes no new request until it has pushed the last one into the queue,
// working out a print's digits one per cycle; a two-entry queue lets it run ahead of the back.
// The back part sends one pixel pair per cycle while out_stall is low; a column is
// ceil((window_bottom - window_top + 1) / 2) pairs, 64 for a full repaint, and the
// next request is taken from the queue in the idle state after the last pair.
// A render command passes the queue, then the back's read stage and output registers.
// A print is written to the text store at the edge at which the back part takes it,
// so a following render always sees it.
// When out_stall is high the output pair holds and the pipeline behind it fills;
// the queue then fills and in_stall rises. Reset empties the queue and pipeline and
// marks every text row blank; no clearing pass is needed.
`default_nettype none

module horizon_column_renderer_with_text
    import hcr_pkg::*;
#(
    parameter int SCREEN_ROWS  = SCREEN_ROWS_DEF,
    parameter int TEXT_ROWS    = TEXT_ROWS_DEF,
    parameter int TEXT_COLUMNS = TEXT_COLUMNS_DEF
)
(
    input  wire               clk,
    input  wire               rst_n,
    input  wire               in_valid,
    output logic              in_stall,
    input  wire               action,
    input  wire  [2:0]        text_row,
    input  wire  [1:0]        colour_index,
    input  wire signed [15:0] value_hundredths,
    input  wire  [6:0]        column,
    input  wire signed [15:0] new_intercept,
    input  wire signed [15:0] old_intercept,
    input  wire               full_repaint,
    output logic              out_valid,
    input  wire               out_stall,
    output logic [6:0]        window_top,
    output logic [6:0]        window_bottom,
    output logic [6:0]        pixel_row,
    output logic [15:0]       colour_first,
    output logic [15:0]       colour_second,
    output logic              second_valid,
    output logic              last
);

    logic      q_push;
    logic      q_full;
    logic      q_valid;
    logic      q_pop;
    hcr_cmd_t  q_wdata;
    hcr_cmd_t  q_rdata;

    hcr_front #(
        .SCREEN_ROWS  (SCREEN_ROWS),
        .TEXT_ROWS    (TEXT_ROWS),
        .TEXT_COLUMNS (TEXT_COLUMNS)
    ) u_front (
        .clk              (clk),
        .rst_n            (rst_n),
        .in_valid         (in_valid),
        .in_stall         (in_stall),
        .action           (action),
        .text_row         (text_row),
        .colour_index     (colour_index),
        .value_hundredths (value_hundredths),
        .column           (column),
        .new_intercept    (new_intercept),
        .old_intercept    (old_intercept),
        .full_repaint     (full_repaint),
        .q_push           (q_push),
        .q_wdata          (q_wdata),
        .q_full           (q_full)
    );

    hcr_queue u_queue (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (q_push),
        .wdata  (q_wdata),
        .full   (q_full),
        .pop    (q_pop),
        .rvalid (q_valid),
        .rdata  (q_rdata)
    );

    hcr_back #(
        .SCREEN_ROWS  (SCREEN_ROWS),
        .TEXT_ROWS    (TEXT_ROWS),
        .TEXT_COLUMNS (TEXT_COLUMNS)
    ) u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .q_valid       (q_valid),
        .q_rdata       (q_rdata),
        .q_pop         (q_pop),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .window_top    (window_top),
        .window_bottom (window_bottom),
        .pixel_row     (pixel_row),
        .colour_first  (colour_first),
        .colour_second (colour_second),
        .second_valid  (second_valid),
        .last          (last)
    );

endmodule

`default_nettype wire

[design/hcr_front.sv]
// Front part: accepts requests, converts printed values to digits, builds print and render commands.
`default_nettype none

module hcr_front
    import hcr_pkg::*;
#(
    parameter int SCREEN_ROWS  = SCREEN_ROWS_DEF,
    parameter int TEXT_ROWS    = TEXT_ROWS_DEF,
    parameter int TEXT_COLUMNS = TEXT_COLUMNS_DEF
)
(
    input  wire               clk,
    input  wire               rst_n,
    input  wire               in_valid,
    output logic              in_stall,
    input  wire               action,
    input  wire  [2:0]        text_row,
    input  wire  [1:0]        colour_index,
    input  wire signed [15:0] value_hundredths,
    input  wire  [6:0]        column,
    input  wire signed [15:0] new_intercept,
    input  wire signed [15:0] old_intercept,
    input  wire               full_repaint,
    output logic              q_push,
    output hcr_cmd_t          q_wdata,
    input  wire               q_full
);

    localparam logic signed [15:0] ROW_MAX_S = 16'(SCREEN_ROWS - 1);
    localparam logic [6:0]         ROW_MAX_U = 7'(SCREEN_ROWS - 1);
    localparam logic [6:0]         TEXT_X_END = 7'(TEXT_COLUMNS * 5);

    hcr_front_state_t state_reg, state_next;

    hcr_kind_t          kind_reg;
    logic [2:0]         row_reg;
    logic [1:0]         colour_reg;
    logic signed [15:0] value_reg;
    logic [6:0]         column_reg;
    logic signed [15:0] yn_reg;
    logic signed [15:0] yo_reg;
    logic               full_reg;
    logic [13:0]        rem_reg, rem_next;
    logic [1:0]         step_reg, step_next;
    logic [2:0][3:0]    digits_reg, digits_next;
    logic               capture;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= F_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (capture)
        begin
            kind_reg   <= action ? KIND_RENDER : KIND_PRINT;
            row_reg    <= text_row;
            colour_reg <= colour_index;
            value_reg  <= value_hundredths;
            column_reg <= column;
            yn_reg     <= new_intercept;
            yo_reg     <= old_intercept;
            full_reg   <= full_repaint;
        end
        rem_reg    <= rem_next;
        step_reg   <= step_next;
        digits_reg <= digits_next;
    end

    always_comb
    begin
        logic [15:0] mag;
        logic [13:0] thr;
        logic [13:0] sub;
        logic [3:0]  dig;
        state_next  = state_reg;
        rem_next    = rem_reg;
        step_next   = step_reg;
        digits_next = digits_reg;
        capture     = 1'b0;
        q_push      = 1'b0;
        in_stall    = (state_reg != F_IDLE);
        mag         = value_reg[15] ? (~value_reg + 16'd1) : value_reg;
        thr         = 14'd0;
        sub         = 14'd0;
        dig         = 4'd0;
        case (state_reg)
            F_IDLE:
            begin
                if (in_valid)
                begin
                    capture = 1'b1;
                    if (action)
                    begin
                        state_next = F_PUSH;
                    end
                    else if ({1'b0, text_row} < 4'(TEXT_ROWS))
                    begin
                        state_next = F_MOD;
                    end
                end
            end
            F_MOD:
            begin
                if (mag >= 16'(3 * PRINT_MOD))
                begin
                    rem_next = 14'(mag - 16'(3 * PRINT_MOD));
                end
                else if (mag >= 16'(2 * PRINT_MOD))
                begin
                    rem_next = 14'(mag - 16'(2 * PRINT_MOD));
                end
                else if (mag >= PRINT_MOD)
                begin
                    rem_next = 14'(mag - PRINT_MOD);
                end
                else
                begin
                    rem_next = 14'(mag);
                end
                step_next  = 2'd0;
                state_next = F_DIGIT;
            end
            F_DIGIT:
            begin
                for (int k = 1; k < 10; k++)
                begin
                    case (step_reg)
                        2'd0:    thr = 14'(k * PLACE_1000);
                        2'd1:    thr = 14'(k * PLACE_100);
                        default: thr = 14'(k * PLACE_10);
                    endcase
                    if (rem_reg >= thr)
                    begin
                        dig = 4'(k);
                        sub = thr;
                    end
                end
                rem_next              = rem_reg - sub;
                digits_next[step_reg] = dig;
                step_next             = step_reg + 2'd1;
                if (step_reg == STEP_LAST)
                begin
                    state_next = F_PUSH;
                end
            end
            F_PUSH:
            begin
                if (!q_full)
                begin
                    q_push     = 1'b1;
                    state_next = F_IDLE;
                end
            end
            default:
            begin
                state_next = F_IDLE;
            end
        endcase
    end

    always_comb
    begin
        logic signed [15:0] lo;
        logic signed [15:0] hi;
        logic [6:0]         top_c;
        logic [6:0]         bottom_c;
        logic [6:0]         base;
        logic [6:0]         slice7;
        logic [2:0]         tcol;
        logic               in_text;
        logic [3:0]         d3;
        logic [3:0]         d2;
        lo = (yn_reg < yo_reg) ? yn_reg : yo_reg;
        hi = (yn_reg < yo_reg) ? yo_reg : yn_reg;
        top_c    = (lo < 0) ? 7'd0 : ((lo > ROW_MAX_S) ? ROW_MAX_U : lo[6:0]);
        bottom_c = (hi < 0) ? 7'd0 : ((hi > ROW_MAX_S) ? ROW_MAX_U : hi[6:0]);
        base = 7'd0;
        tcol = 3'd0;
        for (int k = 1; k < COL_MAX; k++)
        begin
            if (column_reg >= 7'(5 * k))
            begin
                tcol = 3'(k);
                base = 7'(5 * k);
            end
        end
        slice7  = column_reg - base;
        in_text = (column_reg < TEXT_X_END);
        d3 = digits_reg[0];
        d2 = digits_reg[1];

        q_wdata            = '0;
        q_wdata.kind       = kind_reg;
        q_wdata.row        = row_reg;
        q_wdata.cells[0]   = {colour_reg, value_reg[15] ? GLYPH_MINUS : GLYPH_BLANK};
        q_wdata.cells[1]   = {colour_reg, (d3 == 4'd0) ? GLYPH_BLANK : d3};
        q_wdata.cells[2]   = {colour_reg, ((d3 == 4'd0) && (d2 == 4'd0)) ? GLYPH_BLANK : d2};
        q_wdata.cells[3]   = {CI_WHITE, GLYPH_DOT};
        q_wdata.cells[4]   = {colour_reg, digits_reg[2]};
        q_wdata.cells[5]   = {colour_reg, rem_reg[3:0]};
        q_wdata.text_on    = in_text && (slice7 != 7'd4);
        q_wdata.tcol       = tcol;
        q_wdata.slice      = slice7[1:0];
        q_wdata.marker_on  = (column_reg >= MARKER_FIRST) && (column_reg <= MARKER_LAST);
        q_wdata.marker_row = marker_row_of(5'(column_reg - MARKER_FIRST));
        q_wdata.hz_row     = yn_reg[6:0];
        if (yn_reg < 0)
        begin
            q_wdata.hz_mode = HZ_GROUND;
        end
        else if (yn_reg > ROW_MAX_S)
        begin
            q_wdata.hz_mode = HZ_SKY;
        end
        else
        begin
            q_wdata.hz_mode = HZ_SPLIT;
        end
        if (full_reg)
        begin
            q_wdata.top    = 7'd0;
            q_wdata.bottom = ROW_MAX_U;
        end
        else
        begin
            q_wdata.top    = q_wdata.text_on ? 7'd0 : top_c;
            q_wdata.bottom = bottom_c;
        end
    end

endmodule

`default_nettype wire

[design/hcr_queue.sv]
// Short command queue between the front and back parts.
`default_nettype none

module hcr_queue
    import hcr_pkg::*;
(
    input  wire       clk,
    input  wire       rst_n,
    input  wire       push,
    input  hcr_cmd_t  wdata,
    output logic      full,
    input  wire       pop,
    output logic      rvalid,
    output hcr_cmd_t  rdata
);

    hcr_cmd_t           slot_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]  wr_ptr_reg;
    logic [QPTR_W-1:0]  rd_ptr_reg;
    logic [QCNT_W-1:0]  count_reg;

    assign full   = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign rvalid = (count_reg != '0);
    assign rdata  = slot_reg[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= wdata;
        end
    end

endmodule

`default_nettype wire

[design/hcr_back.sv]
// Back part: holds the text rows and turns render commands into pixel pairs.
`default_nettype none

module hcr_back
    import hcr_pkg::*;
#(
    parameter int SCREEN_ROWS  = SCREEN_ROWS_DEF,
    parameter int TEXT_ROWS    = TEXT_ROWS_DEF,
    parameter int TEXT_COLUMNS = TEXT_COLUMNS_DEF
)
(
    input  wire          clk,
    input  wire          rst_n,
    input  wire          q_valid,
    input  hcr_cmd_t     q_rdata,
    output logic         q_pop,
    output logic         out_valid,
    input  wire          out_stall,
    output logic [6:0]   window_top,
    output logic [6:0]   window_bottom,
    output logic [6:0]   pixel_row,
    output logic [15:0]  colour_first,
    output logic [15:0]  colour_second,
    output logic         second_valid,
    output logic         last
);

    localparam int ROW_AW = (TEXT_ROWS > 1) ? $clog2(TEXT_ROWS) : 1;
    localparam int COL_AW = (TEXT_COLUMNS > 1) ? $clog2(TEXT_COLUMNS) : 1;

    hcr_back_state_t state_reg, state_next;

    hcr_cmd_t    cmd_reg;
    logic        cmd_load;
    logic [7:0]  y_reg, y_next;

    hcr_cell_t [TEXT_COLUMNS-1:0] mem_reg [TEXT_ROWS];
    logic [TEXT_ROWS-1:0]         row_valid_reg;
    logic                         mem_we;
    logic [ROW_AW-1:0]            wr_idx;

    logic                         issue;
    logic [ROW_AW-1:0]            rd_idx0;
    logic [ROW_AW-1:0]            rd_idx1;
    logic                         hit0;
    logic                         hit1;
    logic                         pair_second;
    logic                         pair_last;

    logic                         s1_valid_reg;
    logic [6:0]                   s1_y_reg;
    logic                         s1_second_reg;
    logic                         s1_last_reg;
    logic                         s1_hit0_reg;
    logic                         s1_hit1_reg;
    hcr_cell_t [TEXT_COLUMNS-1:0] rd0_reg;
    hcr_cell_t [TEXT_COLUMNS-1:0] rd1_reg;
    logic                         s1_adv;
    logic                         slot_free;

    logic                         out_valid_reg;
    logic [6:0]                   window_top_reg;
    logic [6:0]                   window_bottom_reg;
    logic [6:0]                   pixel_row_reg;
    logic [15:0]                  colour_first_reg;
    logic [15:0]                  colour_second_reg;
    logic                         second_valid_reg;
    logic                         last_reg;
    logic [15:0]                  colour_first_next;
    logic [15:0]                  colour_second_next;

    assign out_valid     = out_valid_reg;
    assign window_top    = window_top_reg;
    assign window_bottom = window_bottom_reg;
    assign pixel_row     = pixel_row_reg;
    assign colour_first  = colour_first_reg;
    assign colour_second = colour_second_reg;
    assign second_valid  = second_valid_reg;
    assign last          = last_reg;

    assign s1_adv    = s1_valid_reg && (!out_valid_reg || !out_stall);
    assign slot_free = !s1_valid_reg || s1_adv;
    assign wr_idx    = q_rdata.row[ROW_AW-1:0];

    always_comb
    begin
        logic [7:0] y1;
        logic [3:0] row0;
        logic [4:0] row1;
        logic       in0;
        logic       in1;
        y1   = y_reg + 8'd1;
        row0 = y_reg[6:3];
        row1 = y1[7:3];
        in0  = ({1'b0, row0} < 5'(TEXT_ROWS));
        in1  = (row1 < 5'(TEXT_ROWS));
        rd_idx0 = in0 ? row0[ROW_AW-1:0] : '0;
        rd_idx1 = in1 ? row1[ROW_AW-1:0] : '0;
        hit0 = cmd_reg.text_on && in0 && (y_reg[2:0] < 3'd5) && row_valid_reg[rd_idx0];
        hit1 = cmd_reg.text_on && in1 && (y1[2:0] < 3'd5) && row_valid_reg[rd_idx1];
        pair_second = (y1 <= {1'b0, cmd_reg.bottom});
        pair_last   = ((y_reg + 8'd2) > {1'b0, cmd_reg.bottom});
    end

    always_comb
    begin
        state_next = state_reg;
        y_next     = y_reg;
        q_pop      = 1'b0;
        mem_we     = 1'b0;
        cmd_load   = 1'b0;
        issue      = 1'b0;
        case (state_reg)
            B_IDLE:
            begin
                if (q_valid && slot_free)
                begin
                    q_pop = 1'b1;
                    if (q_rdata.kind == KIND_RENDER)
                    begin
                        cmd_load   = 1'b1;
                        y_next     = {1'b0, q_rdata.top};
                        state_next = B_RENDER;
                    end
                    else
                    begin
                        mem_we = 1'b1;
                    end
                end
            end
            B_RENDER:
            begin
                if (slot_free)
                begin
                    issue  = 1'b1;
                    y_next = y_reg + 8'd2;
                    if (pair_last)
                    begin
                        state_next = B_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = B_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= B_IDLE;
            row_valid_reg <= '0;
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (mem_we)
            begin
                row_valid_reg[wr_idx] <= 1'b1;
            end
            if (issue)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (s1_adv)
            begin
                s1_valid_reg <= 1'b0;
            end
            out_valid_reg <= s1_adv || (out_valid_reg && out_stall);
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem_reg[wr_idx] <= q_rdata.cells[TEXT_COLUMNS-1:0];
        end
        if (issue)
        begin
            rd0_reg <= mem_reg[rd_idx0];
            rd1_reg <= mem_reg[rd_idx1];
        end
    end

    always_ff @(posedge clk)
    begin
        y_reg <= y_next;
        if (cmd_load)
        begin
            cmd_reg <= q_rdata;
        end
        if (issue)
        begin
            s1_y_reg      <= y_reg[6:0];
            s1_second_reg <= pair_second;
            s1_last_reg   <= pair_last;
            s1_hit0_reg   <= hit0;
            s1_hit1_reg   <= hit1;
        end
        if (s1_adv)
        begin
            window_top_reg    <= cmd_reg.top;
            window_bottom_reg <= cmd_reg.bottom;
            pixel_row_reg     <= s1_y_reg;
            colour_first_reg  <= colour_first_next;
            colour_second_reg <= colour_second_next;
            second_valid_reg  <= s1_second_reg;
            last_reg          <= s1_last_reg;
        end
    end

    always_comb
    begin
        hcr_cell_t c0;
        hcr_cell_t c1;
        c0 = rd0_reg[cmd_reg.tcol[COL_AW-1:0]];
        c1 = rd1_reg[cmd_reg.tcol[COL_AW-1:0]];
        colour_first_next  = pixel_colour(s1_y_reg, cmd_reg, c0, s1_hit0_reg);
        colour_second_next = s1_second_reg ?
                             pixel_colour(s1_y_reg + 7'd1, cmd_reg, c1, s1_hit1_reg) : 16'h0000;
    end

endmodule

`default_nettype wire

[design/hcr_checker.sv]
// Port-level checks on the output channel of the horizon column renderer, bound to the top.
`default_nettype none
`include "horizon_column_renderer_with_text_defines.svh"

module hcr_checker
(
    input wire        clk,
    input wire        rst_n,
    input wire        out_valid,
    input wire        out_stall,
    input wire [6:0]  window_top,
    input wire [6:0]  window_bottom,
    input wire [6:0]  pixel_row,
    input wire [15:0] colour_first,
    input wire [15:0] colour_second,
    input wire        second_valid,
    input wire        last
);

    `HCR_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(pixel_row) && $stable(colour_first))
    `HCR_ASSERT_IMPLY(a_window_order, out_valid, window_top <= window_bottom)
    `HCR_ASSERT_IMPLY(a_row_in_window, out_valid, (pixel_row >= window_top) && (pixel_row <= window_bottom))
    `HCR_ASSERT_IMPLY(a_short_pair_last, out_valid && !second_valid, last && (colour_second == 16'h0000))

endmodule

bind horizon_column_renderer_with_text hcr_checker u_hcr_checker (.*);

`default_nettype wire
